FILE: hw/rtl/des_cfb_pkg.sv
// Shared constants, tables, types and permutation functions for the DES CFB segment cipher.
`default_nettype none

package des_cfb_pkg;

    // Segment width in bits (1 to 63).
    localparam int SEGMENT_BITS = 32;
    localparam int SEG_W        = SEGMENT_BITS;
    localparam logic [63:0] SEG_MASK = (64'd1 << SEGMENT_BITS) - 64'd1;

    localparam int IN_W  = 32;
    localparam int OUT_W = 32;

    localparam int NUM_ROUNDS = 16;
    localparam int ROUND_W    = $clog2(NUM_ROUNDS);

    // Configuration register indexes
    localparam logic CFG_IDX_KEY = 1'b0;
    localparam logic CFG_IDX_DIR = 1'b1;

    // Direction codes
    localparam logic DIR_ENCRYPT = 1'b0;
    localparam logic DIR_DECRYPT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FINISH
    } des_cfb_state_t;

    typedef struct packed {
        logic               load;
        logic               round_en;
        logic [ROUND_W-1:0] round_idx;
        logic               finish;
    } des_cfb_cmd_t;

    // Bit position tables, 1 = most significant bit
    localparam logic [6:0] IP_TAB [0:63] = '{
        7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
        7'd60, 7'd52, 7'd44, 7'd36, 7'd28, 7'd20, 7'd12, 7'd4,
        7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,
        7'd64, 7'd56, 7'd48, 7'd40, 7'd32, 7'd24, 7'd16, 7'd8,
        7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
        7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
        7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21, 7'd13, 7'd5,
        7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7};

    localparam logic [6:0] FP_TAB [0:63] = '{
        7'd40, 7'd8, 7'd48, 7'd16, 7'd56, 7'd24, 7'd64, 7'd32,
        7'd39, 7'd7, 7'd47, 7'd15, 7'd55, 7'd23, 7'd63, 7'd31,
        7'd38, 7'd6, 7'd46, 7'd14, 7'd54, 7'd22, 7'd62, 7'd30,
        7'd37, 7'd5, 7'd45, 7'd13, 7'd53, 7'd21, 7'd61, 7'd29,
        7'd36, 7'd4, 7'd44, 7'd12, 7'd52, 7'd20, 7'd60, 7'd28,
        7'd35, 7'd3, 7'd43, 7'd11, 7'd51, 7'd19, 7'd59, 7'd27,
        7'd34, 7'd2, 7'd42, 7'd10, 7'd50, 7'd18, 7'd58, 7'd26,
        7'd33, 7'd1, 7'd41, 7'd9,  7'd49, 7'd17, 7'd57, 7'd25};

    localparam logic [5:0] E_TAB [0:47] = '{
        6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,
        6'd4,  6'd5,  6'd6,  6'd7,  6'd8,  6'd9,
        6'd8,  6'd9,  6'd10, 6'd11, 6'd12, 6'd13,
        6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
        6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21,
        6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
        6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29,
        6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1};

    localparam logic [5:0] P_TAB [0:31] = '{
        6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
        6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
        6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
        6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25};

    localparam logic [6:0] PC1_TAB [0:55] = '{
        7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,
        7'd1,  7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18,
        7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27,
        7'd19, 7'd11, 7'd3,  7'd60, 7'd52, 7'd44, 7'd36,
        7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15,
        7'd7,  7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22,
        7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37, 7'd29,
        7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4};

    localparam logic [5:0] PC2_TAB [0:47] = '{
        6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,
        6'd3,  6'd28, 6'd15, 6'd6,  6'd21, 6'd10,
        6'd23, 6'd19, 6'd12, 6'd4,  6'd26, 6'd8,
        6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
        6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55,
        6'd30, 6'd40, 6'd51, 6'd45, 6'd33, 6'd48,
        6'd44, 6'd49, 6'd39, 6'd56, 6'd34, 6'd53,
        6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32};

    localparam logic [1:0] ROT_TAB [0:NUM_ROUNDS-1] = '{
        2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
        2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd1};

    localparam logic [3:0] SBOX [0:7][0:63] = '{
        '{4'd14, 4'd4, 4'd13, 4'd1, 4'd2, 4'd15, 4'd11, 4'd8,
          4'd3, 4'd10, 4'd6, 4'd12, 4'd5, 4'd9, 4'd0, 4'd7,
          4'd0, 4'd15, 4'd7, 4'd4, 4'd14, 4'd2, 4'd13, 4'd1,
          4'd10, 4'd6, 4'd12, 4'd11, 4'd9, 4'd5, 4'd3, 4'd8,
          4'd4, 4'd1, 4'd14, 4'd8, 4'd13, 4'd6, 4'd2, 4'd11,
          4'd15, 4'd12, 4'd9, 4'd7, 4'd3, 4'd10, 4'd5, 4'd0,
          4'd15, 4'd12, 4'd8, 4'd2, 4'd4, 4'd9, 4'd1, 4'd7,
          4'd5, 4'd11, 4'd3, 4'd14, 4'd10, 4'd0, 4'd6, 4'd13},
        '{4'd15, 4'd1, 4'd8, 4'd14, 4'd6, 4'd11, 4'd3, 4'd4,
          4'd9, 4'd7, 4'd2, 4'd13, 4'd12, 4'd0, 4'd5, 4'd10,
          4'd3, 4'd13, 4'd4, 4'd7, 4'd15, 4'd2, 4'd8, 4'd14,
          4'd12, 4'd0, 4'd1, 4'd10, 4'd6, 4'd9, 4'd11, 4'd5,
          4'd0, 4'd14, 4'd7, 4'd11, 4'd10, 4'd4, 4'd13, 4'd1,
          4'd5, 4'd8, 4'd12, 4'd6, 4'd9, 4'd3, 4'd2, 4'd15,
          4'd13, 4'd8, 4'd10, 4'd1, 4'd3, 4'd15, 4'd4, 4'd2,
          4'd11, 4'd6, 4'd7, 4'd12, 4'd0, 4'd5, 4'd14, 4'd9},
        '{4'd10, 4'd0, 4'd9, 4'd14, 4'd6, 4'd3, 4'd15, 4'd5,
          4'd1, 4'd13, 4'd12, 4'd7, 4'd11, 4'd4, 4'd2, 4'd8,
          4'd13, 4'd7, 4'd0, 4'd9, 4'd3, 4'd4, 4'd6, 4'd10,
          4'd2, 4'd8, 4'd5, 4'd14, 4'd12, 4'd11, 4'd15, 4'd1,
          4'd13, 4'd6, 4'd4, 4'd9, 4'd8, 4'd15, 4'd3, 4'd0,
          4'd11, 4'd1, 4'd2, 4'd12, 4'd5, 4'd10, 4'd14, 4'd7,
          4'd1, 4'd10, 4'd13, 4'd0, 4'd6, 4'd9, 4'd8, 4'd7,
          4'd4, 4'd15, 4'd14, 4'd3, 4'd11, 4'd5, 4'd2, 4'd12},
        '{4'd7, 4'd13, 4'd14, 4'd3, 4'd0, 4'd6, 4'd9, 4'd10,
          4'd1, 4'd2, 4'd8, 4'd5, 4'd11, 4'd12, 4'd4, 4'd15,
          4'd13, 4'd8, 4'd11, 4'd5, 4'd6, 4'd15, 4'd0, 4'd3,
          4'd4, 4'd7, 4'd2, 4'd12, 4'd1, 4'd10, 4'd14, 4'd9,
          4'd10, 4'd6, 4'd9, 4'd0, 4'd12, 4'd11, 4'd7, 4'd13,
          4'd15, 4'd1, 4'd3, 4'd14, 4'd5, 4'd2, 4'd8, 4'd4,
          4'd3, 4'd15, 4'd0, 4'd6, 4'd10, 4'd1, 4'd13, 4'd8,
          4'd9, 4'd4, 4'd5, 4'd11, 4'd12, 4'd7, 4'd2, 4'd14},
        '{4'd2, 4'd12, 4'd4, 4'd1, 4'd7, 4'd10, 4'd11, 4'd6,
          4'd8, 4'd5, 4'd3, 4'd15, 4'd13, 4'd0, 4'd14, 4'd9,
          4'd14, 4'd11, 4'd2, 4'd12, 4'd4, 4'd7, 4'd13, 4'd1,
          4'd5, 4'd0, 4'd15, 4'd10, 4'd3, 4'd9, 4'd8, 4'd6,
          4'd4, 4'd2, 4'd1, 4'd11, 4'd10, 4'd13, 4'd7, 4'd8,
          4'd15, 4'd9, 4'd12, 4'd5, 4'd6, 4'd3, 4'd0, 4'd14,
          4'd11, 4'd8, 4'd12, 4'd7, 4'd1, 4'd14, 4'd2, 4'd13,
          4'd6, 4'd15, 4'd0, 4'd9, 4'd10, 4'd4, 4'd5, 4'd3},
        '{4'd12, 4'd1, 4'd10, 4'd15, 4'd9, 4'd2, 4'd6, 4'd8,
          4'd0, 4'd13, 4'd3, 4'd4, 4'd14, 4'd7, 4'd5, 4'd11,
          4'd10, 4'd15, 4'd4, 4'd2, 4'd7, 4'd12, 4'd9, 4'd5,
          4'd6, 4'd1, 4'd13, 4'd14, 4'd0, 4'd11, 4'd3, 4'd8,
          4'd9, 4'd14, 4'd15, 4'd5, 4'd2, 4'd8, 4'd12, 4'd3,
          4'd7, 4'd0, 4'd4, 4'd10, 4'd1, 4'd13, 4'd11, 4'd6,
          4'd4, 4'd3, 4'd2, 4'd12, 4'd9, 4'd5, 4'd15, 4'd10,
          4'd11, 4'd14, 4'd1, 4'd7, 4'd6, 4'd0, 4'd8, 4'd13},
        '{4'd4, 4'd11, 4'd2, 4'd14, 4'd15, 4'd0, 4'd8, 4'd13,
          4'd3, 4'd12, 4'd9, 4'd7, 4'd5, 4'd10, 4'd6, 4'd1,
          4'd13, 4'd0, 4'd11, 4'd7, 4'd4, 4'd9, 4'd1, 4'd10,
          4'd14, 4'd3, 4'd5, 4'd12, 4'd2, 4'd15, 4'd8, 4'd6,
          4'd1, 4'd4, 4'd11, 4'd13, 4'd12, 4'd3, 4'd7, 4'd14,
          4'd10, 4'd15, 4'd6, 4'd8, 4'd0, 4'd5, 4'd9, 4'd2,
          4'd6, 4'd11, 4'd13, 4'd8, 4'd1, 4'd4, 4'd10, 4'd7,
          4'd9, 4'd5, 4'd0, 4'd15, 4'd14, 4'd2, 4'd3, 4'd12},
        '{4'd13, 4'd2, 4'd8, 4'd4, 4'd6, 4'd15, 4'd11, 4'd1,
          4'd10, 4'd9, 4'd3, 4'd14, 4'd5, 4'd0, 4'd12, 4'd7,
          4'd1, 4'd15, 4'd13, 4'd8, 4'd10, 4'd3, 4'd7, 4'd4,
          4'd12, 4'd5, 4'd6, 4'd11, 4'd0, 4'd14, 4'd9, 4'd2,
          4'd7, 4'd11, 4'd4, 4'd1, 4'd9, 4'd12, 4'd14, 4'd2,
          4'd0, 4'd6, 4'd10, 4'd13, 4'd15, 4'd3, 4'd5, 4'd8,
          4'd2, 4'd1, 4'd14, 4'd7, 4'd4, 4'd10, 4'd8, 4'd13,
          4'd15, 4'd12, 4'd9, 4'd0, 4'd3, 4'd5, 4'd6, 4'd11}};

    function automatic logic [63:0] des_ip(input logic [63:0] v);
        logic [63:0] r;
        r = '0;
        for (int i = 0; i < 64; i++)
            r[63-i] = v[64 - int'(IP_TAB[i])];
        return r;
    endfunction

    function automatic logic [63:0] des_fp(input logic [63:0] v);
        logic [63:0] r;
        r = '0;
        for (int i = 0; i < 64; i++)
            r[63-i] = v[64 - int'(FP_TAB[i])];
        return r;
    endfunction

    function automatic logic [55:0] des_pc1(input logic [63:0] key);
        logic [55:0] r;
        r = '0;
        for (int i = 0; i < 56; i++)
            r[55-i] = key[64 - int'(PC1_TAB[i])];
        return r;
    endfunction

    function automatic logic [47:0] des_pc2(input logic [55:0] cd);
        logic [47:0] r;
        r = '0;
        for (int i = 0; i < 48; i++)
            r[47-i] = cd[56 - int'(PC2_TAB[i])];
        return r;
    endfunction

    function automatic logic [27:0] des_rot28(input logic [27:0] v, input logic [1:0] amt);
        logic [27:0] r;
        if (amt == 2'd2)
            r = {v[25:0], v[27:26]};
        else
            r = {v[26:0], v[27]};
        return r;
    endfunction

    // Feistel function: expand, key mix, substitute, permute
    function automatic logic [31:0] des_f(input logic [31:0] r, input logic [47:0] sub);
        logic [47:0] x;
        logic [31:0] o;
        logic [31:0] p;
        logic [5:0]  six;
        x = '0;
        o = '0;
        p = '0;
        for (int i = 0; i < 48; i++)
            x[47-i] = r[32 - int'(E_TAB[i])];
        x = x ^ sub;
        for (int i = 0; i < 8; i++) begin
            six = x[47-6*i -: 6];
            o[31-4*i -: 4] = SBOX[i][{six[5], six[0], six[4:1]}];
        end
        for (int i = 0; i < 32; i++)
            p[31-i] = o[32 - int'(P_TAB[i])];
        return p;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/des_cfb_ctrl.sv
// Controller state machine: sequences load, sixteen rounds and the output update.
`default_nettype none

module des_cfb_ctrl
    import des_cfb_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   in_valid,
    output logic        in_stall,
    output logic        out_valid,
    input  wire logic   out_stall,
    output des_cfb_cmd_t cmd
);

    des_cfb_state_t     state_reg, state_next;
    logic [ROUND_W-1:0] round_reg, round_next;
    logic               out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            round_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            round_reg     <= round_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        round_next    = round_reg;
        cmd           = '0;
        cmd.round_idx = round_reg;
        in_stall      = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    round_next = '0;
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                cmd.round_en = 1'b1;
                round_next   = round_reg + 1'b1;
                if (round_reg == ROUND_W'(NUM_ROUNDS - 1))
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                // Wait for room in the output register
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.finish)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/des_cfb_dp.sv
// Datapath: configuration, key schedule, DES round unit, feedback and output registers.
`default_nettype none

module des_cfb_dp
    import des_cfb_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_valid,
    input  wire logic             cfg_ready,
    input  wire logic             cfg_index,
    input  wire logic [63:0]      cfg_data,
    input  wire logic [IN_W-1:0]  segment_in,
    input  wire logic             restart,
    input  wire des_cfb_cmd_t     cmd,
    output logic [OUT_W-1:0]      segment_out
);

    logic [63:0]      key_reg;
    logic             dir_reg;
    logic [63:0]      fb_reg, fb_next;
    logic [27:0]      c_reg, c_next;
    logic [27:0]      d_reg, d_next;
    logic [31:0]      l_reg, l_next;
    logic [31:0]      r_reg, r_next;
    logic [SEG_W-1:0] seg_reg, seg_next;
    logic [OUT_W-1:0] out_reg, out_next;

    logic [63:0] fb_start;
    logic [63:0] ip_block;
    logic [55:0] cd_init;
    logic [27:0] c_rot, d_rot;
    logic [47:0] subkey;
    logic [63:0] des_out;
    logic [63:0] keystream;
    logic [63:0] seg_wide;
    logic [63:0] result;
    logic [63:0] fb_shift_in;
    logic [63:0] seg_in_wide;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
            dir_reg <= DIR_ENCRYPT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_IDX_KEY: key_reg <= cfg_data;
                CFG_IDX_DIR: dir_reg <= cfg_data[0];
                default:     key_reg <= key_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fb_reg <= '0;
        else
            fb_reg <= fb_next;
    end

    always_ff @(posedge clk)
    begin
        c_reg   <= c_next;
        d_reg   <= d_next;
        l_reg   <= l_next;
        r_reg   <= r_next;
        seg_reg <= seg_next;
        out_reg <= out_next;
    end

    always_comb
    begin
        fb_start    = restart ? '0 : fb_reg;
        ip_block    = des_ip(fb_start);
        cd_init     = des_pc1(key_reg);
        seg_in_wide = 64'(segment_in) & SEG_MASK;

        c_rot  = des_rot28(c_reg, ROT_TAB[cmd.round_idx]);
        d_rot  = des_rot28(d_reg, ROT_TAB[cmd.round_idx]);
        subkey = des_pc2({c_rot, d_rot});

        des_out     = des_fp({r_reg, l_reg});
        keystream   = des_out >> (64 - SEGMENT_BITS);
        seg_wide    = 64'(seg_reg);
        result      = (seg_wide ^ keystream) & SEG_MASK;
        fb_shift_in = (dir_reg == DIR_DECRYPT) ? seg_wide : result;

        fb_next  = fb_reg;
        c_next   = c_reg;
        d_next   = d_reg;
        l_next   = l_reg;
        r_next   = r_reg;
        seg_next = seg_reg;
        out_next = out_reg;

        if (cmd.load)
        begin
            fb_next  = fb_start;
            c_next   = cd_init[55:28];
            d_next   = cd_init[27:0];
            l_next   = ip_block[63:32];
            r_next   = ip_block[31:0];
            seg_next = SEG_W'(seg_in_wide);
        end
        else if (cmd.round_en)
        begin
            c_next = c_rot;
            d_next = d_rot;
            l_next = r_reg;
            r_next = l_reg ^ des_f(r_reg, subkey);
        end
        else if (cmd.finish)
        begin
            fb_next  = (fb_reg << SEGMENT_BITS) | fb_shift_in;
            out_next = result[OUT_W-1:0];
        end
    end

    assign segment_out = out_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/des_cfb_segment_cipher_core.sv
// Top level of the DES CFB segment cipher: controller and datapath with stall-based channels.
// An accepted segment goes through the load, sixteen DES rounds on one shared round unit and
// one output/feedback update (ST_IDLE, ST_ROUND, ST_FINISH) before out_valid rises with it;
// for the feedback loop, no new segment is taken until ST_FINISH, which can wait on out_stall, ends.
// A finished result waits in the output register; the block then takes the next beat.
// Reset (rst_n low, asynchronous) clears the feedback register to the all-zero IV,
// the key and direction registers to zero, and empties the output register.
`default_nettype none

module des_cfb_segment_cipher_core
    import des_cfb_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,

    // Configuration write channel
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic             cfg_index,
    input  wire logic [63:0]      cfg_data,

    // Input segment channel
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic [IN_W-1:0]  segment_in,
    input  wire logic             restart,

    // Output segment channel
    output logic                  out_valid,
    input  wire logic             out_stall,
    output logic [OUT_W-1:0]      segment_out
);

    des_cfb_cmd_t cmd;

    // Configuration must be written only while idle; the block does not enforce it, so always take the beat.
    assign cfg_ready = 1'b1;

    // Controller: accepts an input beat when idle, steps the round counter,
    // then holds the finished segment until the output register frees up.
    des_cfb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // Datapath: IP and PC1 on load, one Feistel round per cycle, then FP,
    // keystream XOR and feedback shift on finish.
    des_cfb_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .segment_in  (segment_in),
        .restart     (restart),
        .cmd         (cmd),
        .segment_out (segment_out)
    );

endmodule

`default_nettype wire
